FILE: hw/rtl/sfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int CHANNELS   = 4;
  localparam int MIN_FIELDS = 13;
  localparam int CH_W       = 2;

  localparam logic [7:0] CHAR_START = 8'h3A;  // ':'
  localparam logic [7:0] CHAR_END   = 8'h21;  // '!'
  localparam logic [7:0] CHAR_SEP   = 8'h7C;  // '|'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] FIELD_DEPTH = 4'd8;
  localparam logic [3:0] FIELD_BITS  = 4'd9;
  localparam logic [3:0] FIELD_LAST  = 4'd15;
  localparam logic [3:0] FIELD_OK    = 4'(MIN_FIELDS - 1);
  localparam logic [15:0] NARROW_BITS = 16'd8;

  localparam logic [1:0] ST_HUNT   = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_DATA   = 2'd2;

  localparam logic [1:0] EV_DATA   = 2'd0;
  localparam logic [1:0] EV_HEADER = 2'd1;
  localparam logic [1:0] EV_DONE   = 2'd2;
  localparam logic [1:0] EV_STRAY  = 2'd3;

  typedef struct packed {
    logic       adv;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]      event_res;
    logic [CH_W-1:0] channel;
    logic [7:0]      sample_byte;
    logic [16:0]     sample_index;
    logic            header_ok;
    logic [3:0]      channel_mask;
    logic [15:0]     mem_depth;
    logic            wide_samples;
  } result_t;

  // lowest enabled channel at or above from; channel 0 if none
  function automatic logic [CH_W-1:0] next_channel(input logic [CH_W:0] from,
                                                   input logic [CHANNELS-1:0] mask);
    logic [CH_W-1:0] r;
    logic            found;
    r     = '0;
    found = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (!found && (c >= int'(from)) && mask[c]) begin
        r     = CH_W'(c);
        found = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sfd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic [1:0]  channel;
  logic [7:0]  sample_byte;
  logic [16:0] sample_index;
  logic        header_ok;
  logic [3:0]  channel_mask;
  logic [15:0] mem_depth;
  logic        wide_samples;

  modport source (output valid, output event_res, output channel, output sample_byte,
                  output sample_index, output header_ok, output channel_mask,
                  output mem_depth, output wide_samples, input ready);
  modport sink   (input valid, input event_res, input channel, input sample_byte,
                  input sample_index, input header_ok, input channel_mask,
                  input mem_depth, input wide_samples, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_in_stage (
  input  wire logic    clk,
  input  wire logic    rst_n,
  sfd_in_if.sink       in_ch,
  input  wire logic    out_free,
  output sfd_pkg::item_t item
);
  import sfd_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       adv;
  logic       take;

  // advance the held word whenever the result register can take it
  assign adv         = valid_r && out_free;
  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.rx_byte;
    end
  end

  assign item.adv     = adv;
  assign item.rx_byte = byte_r;

endmodule

`default_nettype wire

FILE: hw/rtl/sfd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire sfd_pkg::item_t item,
  output logic                produce,
  output sfd_pkg::result_t    res
);
  import sfd_pkg::*;

  logic [1:0]          stage_r, stage_nxt;
  logic [3:0]          fnum_r, fnum_nxt;
  logic [15:0]         fval_r, fval_nxt;
  logic                finv_r, finv_nxt;
  logic [CHANNELS-1:0] pmask_r, pmask_nxt;
  logic [15:0]         pdepth_r, pdepth_nxt;
  logic                pnarrow_r, pnarrow_nxt;
  logic [CHANNELS-1:0] amask_r, amask_nxt;
  logic [15:0]         adepth_r, adepth_nxt;
  logic                anarrow_r, anarrow_nxt;
  logic [16:0]         bpc_r, bpc_nxt;
  logic [CH_W-1:0]     slot_r, slot_nxt;
  logic [16:0]         bic_r, bic_nxt;
  logic [18:0]         left_r, left_nxt;

  logic [7:0]          b;
  logic [15:0]         cv;
  logic [CHANNELS-1:0] cl_mask;
  logic [15:0]         cl_depth;
  logic                cl_narrow;
  logic [19:0]         acc;
  logic                is_digit;
  logic [2:0]          pop;
  logic [18:0]         bpc_w;
  logic [17:0]         bic_inc;

  assign b        = item.rx_byte;
  assign cv       = finv_r ? 16'd0 : fval_r;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  // value * 10 + digit
  assign acc      = {1'b0, fval_r, 3'b000} + {3'b000, fval_r, 1'b0}
                  + {12'd0, b - CHAR_ZERO};
  assign bic_inc  = {1'b0, bic_r} + 18'd1;

  // field values as they stand once the current field is closed
  always_comb begin
    cl_mask   = pmask_r;
    cl_depth  = pdepth_r;
    cl_narrow = pnarrow_r;
    if (fnum_r[3:2] == 2'b01) begin
      cl_mask[fnum_r[1:0]] = (cv != 16'd0);
    end else if (fnum_r == FIELD_DEPTH) begin
      cl_depth = cv;
    end else if (fnum_r == FIELD_BITS) begin
      cl_narrow = (cv == NARROW_BITS);
    end
  end

  always_comb begin
    stage_nxt   = stage_r;
    fnum_nxt    = fnum_r;
    fval_nxt    = fval_r;
    finv_nxt    = finv_r;
    pmask_nxt   = pmask_r;
    pdepth_nxt  = pdepth_r;
    pnarrow_nxt = pnarrow_r;
    amask_nxt   = amask_r;
    adepth_nxt  = adepth_r;
    anarrow_nxt = anarrow_r;
    bpc_nxt     = bpc_r;
    slot_nxt    = slot_r;
    bic_nxt     = bic_r;
    left_nxt    = left_r;
    produce     = 1'b0;
    pop         = 3'd0;
    bpc_w       = 19'd0;
    res.event_res    = EV_DATA;
    res.channel      = '0;
    res.sample_byte  = 8'd0;
    res.sample_index = 17'd0;
    res.header_ok    = 1'b0;

    unique case (stage_r)
      ST_HEADER: begin
        if (b == CHAR_START) begin
          produce       = 1'b1;
          res.event_res = EV_HEADER;
          res.header_ok = (fnum_r >= FIELD_OK);
          fval_nxt      = 16'd0;
          finv_nxt      = 1'b0;
          pmask_nxt     = cl_mask;
          pdepth_nxt    = cl_depth;
          pnarrow_nxt   = cl_narrow;
          if (fnum_r >= FIELD_OK) begin
            amask_nxt   = cl_mask;
            adepth_nxt  = cl_depth;
            anarrow_nxt = cl_narrow;
          end
          bpc_nxt  = anarrow_nxt ? {1'b0, adepth_nxt} : {adepth_nxt, 1'b0};
          bpc_w    = {2'b00, bpc_nxt};
          pop      = 3'($countones(amask_nxt));
          case (pop)
            3'd1:    left_nxt = bpc_w;
            3'd2:    left_nxt = {bpc_w[17:0], 1'b0};
            3'd3:    left_nxt = bpc_w + {bpc_w[17:0], 1'b0};
            3'd4:    left_nxt = {bpc_w[16:0], 2'b00};
            default: left_nxt = 19'd0;
          endcase
          bic_nxt   = 17'd0;
          slot_nxt  = next_channel('0, amask_nxt);
          stage_nxt = ST_DATA;
        end else if (b == CHAR_SEP) begin
          fval_nxt    = 16'd0;
          finv_nxt    = 1'b0;
          pmask_nxt   = cl_mask;
          pdepth_nxt  = cl_depth;
          pnarrow_nxt = cl_narrow;
          if (fnum_r != FIELD_LAST) begin
            fnum_nxt = fnum_r + 4'd1;
          end
        end else if (is_digit) begin
          fval_nxt = (acc[19:16] != 4'd0) ? 16'hFFFF : acc[15:0];
        end else begin
          finv_nxt = 1'b1;
        end
      end
      ST_DATA: begin
        produce = 1'b1;
        if (left_r != 19'd0) begin
          res.event_res    = EV_DATA;
          res.channel      = slot_r;
          res.sample_byte  = b;
          res.sample_index = bic_r;
          left_nxt         = left_r - 19'd1;
          bic_nxt          = bic_inc[16:0];
          if (bic_inc >= {1'b0, bpc_r}) begin
            bic_nxt  = 17'd0;
            slot_nxt = next_channel({1'b0, slot_r} + 3'd1, amask_r);
          end
        end else if (b == CHAR_END) begin
          res.event_res = EV_DONE;
          stage_nxt     = ST_HUNT;
        end else begin
          res.event_res   = EV_STRAY;
          res.sample_byte = b;
        end
      end
      default: begin
        // hunt; the unused code behaves the same
        if (b == CHAR_START) begin
          stage_nxt   = ST_HEADER;
          fnum_nxt    = 4'd0;
          fval_nxt    = 16'd0;
          finv_nxt    = 1'b0;
          pmask_nxt   = '0;
          pdepth_nxt  = 16'd0;
          pnarrow_nxt = 1'b0;
        end else begin
          stage_nxt = ST_HUNT;
        end
      end
    endcase

    res.channel_mask = amask_nxt;
    res.mem_depth    = adepth_nxt;
    res.wide_samples = !anarrow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r   <= ST_HUNT;
      fnum_r    <= 4'd0;
      fval_r    <= 16'd0;
      finv_r    <= 1'b0;
      pmask_r   <= '0;
      pdepth_r  <= 16'd0;
      pnarrow_r <= 1'b0;
      amask_r   <= '0;
      adepth_r  <= 16'd0;
      anarrow_r <= 1'b0;
      bpc_r     <= 17'd0;
      slot_r    <= '0;
      bic_r     <= 17'd0;
      left_r    <= 19'd0;
    end else if (item.adv) begin
      stage_r   <= stage_nxt;
      fnum_r    <= fnum_nxt;
      fval_r    <= fval_nxt;
      finv_r    <= finv_nxt;
      pmask_r   <= pmask_nxt;
      pdepth_r  <= pdepth_nxt;
      pnarrow_r <= pnarrow_nxt;
      amask_r   <= amask_nxt;
      adepth_r  <= adepth_nxt;
      anarrow_r <= anarrow_nxt;
      bpc_r     <= bpc_nxt;
      slot_r    <= slot_nxt;
      bic_r     <= bic_nxt;
      left_r    <= left_nxt;
    end
  end

  a_left_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (item.adv && stage_r == ST_DATA && left_r != 19'd0) |=> left_r == $past(left_r) - 19'd1)
    else $error("payload byte count did not step down");

  a_index_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_DATA && left_r != 19'd0) |-> bic_r < bpc_r)
    else $error("byte index ran past the channel block");

  a_slot_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_DATA && left_r != 19'd0) |-> amask_r[slot_r])
    else $error("payload byte tagged with a disabled channel");

endmodule

`default_nettype wire

FILE: hw/rtl/sfd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module sfd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             produce,
  input  wire sfd_pkg::result_t res,
  output logic                  out_free,
  sfd_out_if.source             out_ch
);
  import sfd_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r && !out_ch.ready;
    if (adv) begin
      valid_nxt = produce;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && produce) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_res    = res_r.event_res;
  assign out_ch.channel      = res_r.channel;
  assign out_ch.sample_byte  = res_r.sample_byte;
  assign out_ch.sample_index = res_r.sample_index;
  assign out_ch.header_ok    = res_r.header_ok;
  assign out_ch.channel_mask = res_r.channel_mask;
  assign out_ch.mem_depth    = res_r.mem_depth;
  assign out_ch.wide_samples = res_r.wide_samples;

endmodule

`default_nettype wire

FILE: hw/rtl/scope_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial frame deframer for a sampling-scope link. It takes one byte per
// clock unless stalled and gives at most one result word per byte. A byte is held
// in an input register; its result word is loaded from there into the result
// register, from which it is taken, so bytes and result words both flow back to
// back. A result word left waiting stalls the core: the input register takes at
// most one more byte and input then stops until the word is taken.
// Header fields (':' ... '|' ... ':') and payload bytes are handled in the single
// logic step between those registers; bytes of the hunt phase and header bytes
// other than the closing ':' give no result. A header of at least 13 fields
// commits channel enables, depth and sample width; payload bytes are then tagged
// with channel and index, followed by a frame-complete word on '!' or a stray word
// for any other byte.
module scope_frame_deframer (
  input  wire logic clk,
  input  wire logic rst_n,
  sfd_in_if.sink    in_ch,
  sfd_out_if.source out_ch
);
  import sfd_pkg::*;

  item_t   item;
  result_t res;
  logic    produce;
  logic    out_free;

  sfd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .item     (item)
  );

  sfd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .produce (produce),
    .res     (res)
  );

  sfd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (item.adv),
    .produce  (produce),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire
